// File: sv/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is high.
`define DOST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked through reset.
`define DOST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/dost_pkg.sv
// Shared types and phase codes for the delayed one-shot timer.
package dost_pkg;

  typedef enum logic [1:0] {
    PH_READY   = 2'd0,
    PH_DELAY   = 2'd1,
    PH_HOLD    = 2'd2,
    PH_WAITLOW = 2'd3
  } phase_t;

  // Control part of the timer state.
  typedef struct packed {
    phase_t phase;
    logic   level;
  } dost_ctl_t;

  // Per-request flags that steer the tick.
  typedef struct packed {
    logic running;
    logic trigger;
  } dost_tick_t;

  // Result flags of one tick.
  typedef struct packed {
    logic pulse;
    logic changed;
  } dost_res_t;

endpackage

// File: sv/dost_core.sv
// Next-state and result logic for one tick of the one-shot timer.
module dost_core
  import dost_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  dost_ctl_t              ctl,
  input  logic [TIME_WIDTH-1:0]  deadline,
  input  dost_tick_t             tick,
  input  logic [TIME_WIDTH-1:0]  now_time,
  input  logic [TIME_WIDTH-1:0]  delay_time,
  input  logic [TIME_WIDTH-1:0]  hold_time,
  output dost_ctl_t              ctl_next,
  output logic [TIME_WIDTH-1:0]  deadline_next,
  output dost_res_t              res
);

  logic [TIME_WIDTH:0]   sum_dly;
  logic [TIME_WIDTH:0]   sum_hld;
  logic [TIME_WIDTH-1:0] end_dly;
  logic [TIME_WIDTH-1:0] end_hld;
  logic                  expired;
  logic                  now_zero;

  // Saturating deadline sums and the expiry compare
  assign sum_dly  = {1'b0, now_time} + {1'b0, delay_time};
  assign sum_hld  = {1'b0, now_time} + {1'b0, hold_time};
  assign end_dly  = sum_dly[TIME_WIDTH] ? '1 : sum_dly[TIME_WIDTH-1:0];
  assign end_hld  = sum_hld[TIME_WIDTH] ? '1 : sum_hld[TIME_WIDTH-1:0];
  assign expired  = (deadline <= now_time);
  assign now_zero = (now_time == '0);

  // Advance the phase, deadline and level
  always_comb begin
    ctl_next      = ctl;
    deadline_next = deadline;
    if (!tick.running) begin
      if (now_zero) begin
        ctl_next.phase = PH_READY;
        ctl_next.level = 1'b0;
        deadline_next  = '0;
      end
    end else begin
      unique case (ctl.phase)
        PH_READY: begin
          if (tick.trigger) begin
            if (delay_time == '0) begin
              ctl_next.phase = PH_HOLD;
              ctl_next.level = 1'b1;
              deadline_next  = end_hld;
            end else begin
              ctl_next.phase = PH_DELAY;
              deadline_next  = end_dly;
            end
          end
        end
        PH_DELAY: begin
          if (expired) begin
            ctl_next.phase = PH_HOLD;
            ctl_next.level = 1'b1;
            deadline_next  = end_hld;
          end
        end
        PH_HOLD: begin
          if (expired) begin
            ctl_next.phase = tick.trigger ? PH_WAITLOW : PH_READY;
            ctl_next.level = 1'b0;
          end
        end
        PH_WAITLOW: begin
          if (!tick.trigger) begin
            ctl_next.phase = PH_READY;
          end
        end
        default: begin
          ctl_next.phase = PH_READY;
        end
      endcase
    end
  end

  // Drive the result: new level, and a flag when it switched
  always_comb begin
    res.pulse   = ctl_next.level;
    res.changed = ctl_next.level ^ ctl.level;
  end

endmodule

// File: sv/delayed_one_shot_timer.sv
// Top level of the delayed one-shot timer with input and result registers.
//
// Non-retriggerable one-shot with a start delay, evaluated once per tick
// request. Each request on the input channel (in_valid / in_stall) carries
// the current time, the clock-running flag, the trigger level and the
// delay and hold times. Each request gives exactly one result on the
// output channel (out_valid / out_stall): pulse_out, its complement
// pulse_out_n, and changed when the output switched on that tick.
// An accepted request sits in the input register until the result register
// is free; the tick logic then writes the result register and the timer
// state together.
// Throughput is one request per cycle while the receiver does not stall,
// set by the single state update per tick.
// While the receiver stalls, the result holds, the input register keeps
// one request, and in_stall rises only once both are full.
// Synchronous reset empties both registers and returns the timer to the
// ready phase with the output low and the deadline at zero.
module delayed_one_shot_timer
  import dost_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_WIDTH-1:0] now_time,
  input  logic                  clock_running,
  input  logic                  trigger,
  input  logic [TIME_WIDTH-1:0] delay_time,
  input  logic [TIME_WIDTH-1:0] hold_time,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  pulse_out,
  output logic                  pulse_out_n,
  output logic                  changed
);

  logic                  req_vld;
  logic [TIME_WIDTH-1:0] req_now;
  logic [TIME_WIDTH-1:0] req_dly;
  logic [TIME_WIDTH-1:0] req_hld;
  dost_tick_t            req_tick;

  dost_ctl_t             ctl;
  dost_ctl_t             ctl_next;
  logic [TIME_WIDTH-1:0] deadline;
  logic [TIME_WIDTH-1:0] deadline_next;
  dost_res_t             res;

  logic                  advance;
  logic                  accept;

  // Handshake: move a request on whenever the result register is free
  assign advance  = req_vld && (!out_valid || !out_stall);
  assign in_stall = req_vld && !advance;
  assign accept   = in_valid && !in_stall;

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else if (accept) begin
      req_vld <= 1'b1;
    end else if (advance) begin
      req_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_now          <= now_time;
      req_dly          <= delay_time;
      req_hld          <= hold_time;
      req_tick.running <= clock_running;
      req_tick.trigger <= trigger;
    end
  end

  dost_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .ctl           (ctl),
    .deadline      (deadline),
    .tick          (req_tick),
    .now_time      (req_now),
    .delay_time    (req_dly),
    .hold_time     (req_hld),
    .ctl_next      (ctl_next),
    .deadline_next (deadline_next),
    .res           (res)
  );

  // Update the timer state once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.phase <= PH_READY;
      ctl.level <= 1'b0;
      deadline  <= '0;
    end else if (advance) begin
      ctl      <= ctl_next;
      deadline <= deadline_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pulse_out   <= res.pulse;
      pulse_out_n <= !res.pulse;
      changed     <= res.changed;
    end
  end

endmodule

// File: sv/dost_checker.sv
// Port-level checker for the delayed one-shot timer, bound to the top level.
`include "assert_macros.svh"

module dost_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic pulse_out,
  input logic pulse_out_n,
  input logic changed
);

  logic last_level;
  logic take;
  logic held;
  logic switched;

  // Name the result handshake states
  assign take     = out_valid && !out_stall;
  assign held     = out_valid && out_stall;
  assign switched = (pulse_out != last_level);

  // Track the level of the last delivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= 1'b0;
    end else if (take) begin
      last_level <= pulse_out;
    end
  end

  `DOST_ASSERT(a_complement, out_valid |-> (pulse_out_n != pulse_out), "pulse_out_n wrong")
  `DOST_ASSERT(a_changed, take |-> (changed == switched), "changed flag wrong")
  `DOST_ASSERT(a_hold, held |=> out_valid && $stable(pulse_out) && $stable(changed), "stall lost")
  `DOST_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

endmodule

bind delayed_one_shot_timer dost_checker u_dost_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pulse_out   (pulse_out),
  .pulse_out_n (pulse_out_n),
  .changed     (changed)
);

// File: test/tb_delayed_one_shot_timer.sv
// Self-checking testbench for the delayed one-shot timer.
module tb_delayed_one_shot_timer;
  import dost_pkg::*;

  localparam int TIME_W = 32;

  typedef logic [TIME_W-1:0] tick_t;

  typedef enum int {
    TRAFFIC_FREE,
    TRAFFIC_SENDER_IDLE,
    TRAFFIC_RECEIVER_STALL,
    TRAFFIC_BOTH,
    TRAFFIC_PRESSURE
  } traffic_t;

  // One result of a tick request, as the block should present it.
  typedef struct packed {
    logic pulse;
    logic pulse_n;
    logic switched;
  } pulse_result_t;

  // Track the timer state and hold the pulse results still owed by the block.
  class pulse_scoreboard;
    phase_t        timer_phase;
    tick_t         deadline;
    logic          level;
    pulse_result_t expected_pulses[$];
    int            errors;

    function new();
      timer_phase = PH_READY;
      deadline    = '0;
      level       = 1'b0;
      errors      = 0;
    endfunction

    function tick_t sat_sum(input tick_t a, input tick_t b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

    // Advance the timer by one accepted request and queue its result.
    function void note_request(input tick_t t, input logic run, input logic trg,
                               input tick_t dly, input tick_t hld);
      pulse_result_t res;
      res.switched = 1'b0;
      if (!run) begin
        // stopped clock at time zero clears everything
        if (t == '0) begin
          res.switched = level;
          timer_phase  = PH_READY;
          deadline     = '0;
          level        = 1'b0;
        end
      end else begin
        case (timer_phase)
          PH_READY: begin
            if (trg) begin
              if (dly == '0) begin
                timer_phase  = PH_HOLD;
                deadline     = sat_sum(t, hld);
                res.switched = ~level;
                level        = 1'b1;
              end else begin
                timer_phase = PH_DELAY;
                deadline    = sat_sum(t, dly);
              end
            end
          end
          PH_DELAY: begin
            if (deadline <= t) begin
              timer_phase  = PH_HOLD;
              deadline     = sat_sum(t, hld);
              res.switched = ~level;
              level        = 1'b1;
            end
          end
          PH_HOLD: begin
            if (deadline <= t) begin
              timer_phase  = trg ? PH_WAITLOW : PH_READY;
              res.switched = level;
              level        = 1'b0;
            end
          end
          default: begin
            if (!trg) timer_phase = PH_READY;
          end
        endcase
      end
      res.pulse   = level;
      res.pulse_n = ~level;
      expected_pulses = {expected_pulses, res};
    endfunction

    // Compare one accepted result with the oldest pending one.
    function void check_result(input logic p, input logic pn, input logic sw);
      pulse_result_t want;
      if (expected_pulses.size() == 0) begin
        $display("%0t: unexpected result pulse=%b pulse_n=%b changed=%b", $time, p, pn, sw);
        errors++;
        return;
      end
      want = expected_pulses.pop_front();
      if (p !== want.pulse || pn !== want.pulse_n || sw !== want.switched) begin
        $display("%0t: mismatch pulse exp %b act %b, pulse_n exp %b act %b, changed exp %b act %b",
                 $time, want.pulse, p, want.pulse_n, pn, want.switched, sw);
        errors++;
      end
    endfunction

    function int pending();
      return expected_pulses.size();
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  tick_t now_time = '0;
  logic  clock_running = 1'b0;
  logic  trigger = 1'b0;
  tick_t delay_time = '0;
  tick_t hold_time = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  logic  pulse_out;
  logic  pulse_out_n;
  logic  changed;

  pulse_scoreboard scoreboard;
  int              stall_pct = 0;
  logic            pressure_on = 1'b0;
  int              hold_count = 0;
  tick_t           wall_clock = '0;
  logic            trig_level = 1'b0;

  delayed_one_shot_timer #(
    .TIME_WIDTH(TIME_W)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .now_time     (now_time),
    .clock_running(clock_running),
    .trigger      (trigger),
    .delay_time   (delay_time),
    .hold_time    (hold_time),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pulse_out    (pulse_out),
    .pulse_out_n  (pulse_out_n),
    .changed      (changed)
  );

  always #5 clk = ~clk;

  // Take results and drive the receiver stall, with long hold-offs under pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      hold_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        scoreboard.check_result(pulse_out, pulse_out_n, changed);
      end
      if (pressure_on) begin
        hold_count <= (hold_count == 99) ? 0 : hold_count + 1;
        out_stall  <= (hold_count < 70);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one tick request and wait until the block takes it.
  task automatic offer_tick(input tick_t t, input logic run, input logic trg,
                            input tick_t dly, input tick_t hld, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    now_time      <= t;
    clock_running <= run;
    trigger       <= trg;
    delay_time    <= dly;
    hold_time     <= hld;
    do @(posedge clk); while (in_stall);
    scoreboard.note_request(t, run, trg, dly, hld);
  endtask

  function automatic tick_t pick_duration(input int zero_pct);
    int r;
    r = $urandom_range(99);
    if (r < zero_pct) return '0;
    if (r < 85) return tick_t'($urandom_range(12, 1));
    if (r < 95) return tick_t'($urandom);
    return '1 - tick_t'($urandom_range(3));
  endfunction

  // Build a request: mostly a running clock with a slowly advancing time,
  // with some stopped-clock resets, jumps near the top of the range and noise.
  task automatic random_tick(input int idle_pct);
    int    pick;
    tick_t t;
    logic  run;
    pick = $urandom_range(99);
    run  = 1'b1;
    if ($urandom_range(3) == 0) trig_level = ~trig_level;
    if (pick < 3) begin
      t          = tick_t'($urandom);
      run        = 1'($urandom_range(1));
      trig_level = 1'($urandom_range(1));
    end else if (pick < 6) begin
      t          = '0;
      run        = 1'b0;
      wall_clock = '0;
    end else if (pick < 8) begin
      t   = tick_t'($urandom_range(32'hFFFF_FFFF, 1));
      run = 1'b0;
    end else begin
      if (pick < 10) wall_clock = '1 - tick_t'($urandom_range(40));
      else wall_clock = wall_clock + tick_t'($urandom_range(3));
      t = wall_clock;
    end
    offer_tick(t, run, trig_level, pick_duration(30), pick_duration(15), idle_pct);
  endtask

  task automatic run_traffic(input traffic_t mode, input int count);
    int send_pct;
    send_pct = 0;
    case (mode)
      TRAFFIC_SENDER_IDLE:    send_pct = 56;
      TRAFFIC_BOTH:           send_pct = 22;
      default:                send_pct = 0;
    endcase
    case (mode)
      TRAFFIC_RECEIVER_STALL: stall_pct <= 56;
      TRAFFIC_BOTH:           stall_pct <= 22;
      default:                stall_pct <= 0;
    endcase
    pressure_on <= (mode == TRAFFIC_PRESSURE);
    repeat (count) random_tick(send_pct);
  endtask

  // Stop a hung run.
  initial begin
    #2_000_000;
    $display("delayed_one_shot_timer verification failed");
    $finish;
  end

  initial begin
    scoreboard = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk through delay, hold and wait-for-low, then the special cases.
    offer_tick(32'd0, 1'b1, 1'b0, 32'd3, 32'd2, 0);
    offer_tick(32'd1, 1'b1, 1'b1, 32'd3, 32'd2, 0);
    offer_tick(32'd2, 1'b1, 1'b0, 32'd3, 32'd2, 0);
    offer_tick(32'd4, 1'b1, 1'b0, 32'd3, 32'd2, 0);
    offer_tick(32'd5, 1'b1, 1'b1, 32'd3, 32'd2, 0);
    offer_tick(32'd6, 1'b1, 1'b1, 32'd3, 32'd2, 0);
    offer_tick(32'd7, 1'b1, 1'b1, 32'd3, 32'd2, 0);
    offer_tick(32'd8, 1'b1, 1'b0, 32'd3, 32'd2, 0);
    // zero delay turns on at once
    offer_tick(32'd9, 1'b1, 1'b1, 32'd0, 32'd3, 0);
    // stopped clock: nonzero time keeps state, zero time clears it
    offer_tick(32'd10, 1'b0, 1'b1, 32'd0, 32'd3, 0);
    offer_tick(32'd0, 1'b0, 1'b0, 32'd0, 32'd3, 0);
    // saturating deadlines at the top of the time range
    offer_tick(32'hFFFF_FFF0, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'd5, 0);
    offer_tick(32'hFFFF_FFFE, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'd5, 0);
    offer_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'd5, 0);
    offer_tick(32'hFFFF_FFFF, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'd5, 0);
    offer_tick(32'd0, 1'b0, 1'b0, 32'd0, 32'd0, 0);
    // zero delay and zero hold
    offer_tick(32'd0, 1'b1, 1'b1, 32'd0, 32'd0, 0);
    offer_tick(32'd0, 1'b1, 1'b1, 32'd0, 32'd0, 0);
    offer_tick(32'd0, 1'b0, 1'b1, 32'd0, 32'd0, 0);
    offer_tick(32'd100, 1'b1, 1'b1, 32'd0, 32'hFFFF_FFFF, 0);
    offer_tick(32'd0, 1'b0, 1'b1, 32'd0, 32'd0, 0);
    offer_tick(32'd0, 1'b1, 1'b1, 32'd5, 32'd5, 0);
    offer_tick(32'd0, 1'b0, 1'b0, 32'd5, 32'd5, 0);
    wall_clock = '0;

    run_traffic(TRAFFIC_FREE, 300);
    run_traffic(TRAFFIC_SENDER_IDLE, 310);
    run_traffic(TRAFFIC_RECEIVER_STALL, 310);
    run_traffic(TRAFFIC_BOTH, 310);
    run_traffic(TRAFFIC_PRESSURE, 320);
    in_valid    <= 1'b0;
    pressure_on <= 1'b0;
    stall_pct   <= 0;

    // Drain the outstanding results, then watch for strays.
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (scoreboard.errors == 0) begin
      $display("delayed_one_shot_timer verification clean");
    end else begin
      $display("delayed_one_shot_timer verification failed");
    end
    $finish;
  end

endmodule

// File: delayed_one_shot_timer.f
+incdir+sv
sv/dost_pkg.sv
sv/dost_core.sv
sv/delayed_one_shot_timer.sv
sv/dost_checker.sv
test/tb_delayed_one_shot_timer.sv
